// ===== design/slot_allocator_with_wait_queue_macros.svh =====
// Assertion macros used by the port-level checker of the slot allocator.
// Depends on a clock named clk and a synchronous reset named rst in scope.
`ifndef SLOT_ALLOCATOR_WITH_WAIT_QUEUE_MACROS_SVH
`define SLOT_ALLOCATOR_WITH_WAIT_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAWQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SAWQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sawq_pkg.sv =====
// Package of the slot allocator: sizes, operation and status codes,
// request and result types, sequencer states. Depends on nothing.
package sawq_pkg;

  localparam int SLOTS      = 8;
  localparam int WAIT_DEPTH = 5;
  localparam int TAG_BITS   = 16;

  localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WAIT_IDX_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int FILL_W     = $clog2(WAIT_DEPTH + 1);

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic [2:0] STATUS_ALLOCATED    = 3'd0;
  localparam logic [2:0] STATUS_QUEUED       = 3'd1;
  localparam logic [2:0] STATUS_REJECTED     = 3'd2;
  localparam logic [2:0] STATUS_RELEASED     = 3'd3;
  localparam logic [2:0] STATUS_ALREADY_FREE = 3'd4;
  localparam logic [2:0] STATUS_INVALID      = 3'd5;

  typedef struct packed {
    logic        func;
    logic [15:0] requester_tag;
    logic [3:0]  slot_number;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot_out;
    logic [15:0] tag_out;
    logic [2:0]  waiting_count;
    logic        last;
  } res_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_EXEC,
    SEQ_SECOND
  } seq_state_t;

endpackage

// ===== design/slot_allocator_with_wait_queue.sv =====
// Slot allocator with a waiting queue: top level.
// Depends on sawq_pkg and sawq_ram.
//
// Each request is taken while the sequencer is idle and occupies it until its
// results are loaded into the output register. The registered read of the tag
// and queue RAMs is issued at accept, and the execute state then loads the
// result of every request. A release that hands its slot to a waiter passes
// through a second state too and gives two results, the release and then the
// allocation. The sequencer stays in a state only while the output register is
// stalled. Slot occupancy sits in flip-flops cleared by reset, so no clearing
// pass is needed.
module slot_allocator_with_wait_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  sawq_pkg::req_t  req_data,
  output logic            res_valid,
  input  logic            res_stall,
  output sawq_pkg::res_t  res_data
);

  sawq_pkg::seq_state_t state, state_next;

  logic [sawq_pkg::SLOTS-1:0]      busy;
  logic [sawq_pkg::WAIT_IDX_W-1:0] head, tail;
  logic [sawq_pkg::FILL_W-1:0]     fill;

  logic                            cur_func;
  logic [15:0]                     cur_tag;
  logic [3:0]                      cur_num;

  logic                            accept, out_free;
  logic                            free_found;
  logic [sawq_pkg::SLOT_IDX_W-1:0] free_idx, rel_idx;
  logic                            num_valid, rel_busy, rel_chain;
  logic                            queue_room;
  logic [15:0]                     alloc_tag;

  logic [sawq_pkg::TAG_BITS-1:0]   tag_rdata, wait_rdata;
  logic                            tag_we, wait_we;
  logic                            busy_set, busy_clr, push, pop, load_out;
  sawq_pkg::res_t                  alloc_res, out_next;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != sawq_pkg::SEQ_IDLE);
  assign out_free  = !res_valid || !res_stall;

  sawq_ram #(
    .WIDTH (sawq_pkg::TAG_BITS),
    .DEPTH (sawq_pkg::SLOTS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (free_idx),
    .wdata (alloc_tag[sawq_pkg::TAG_BITS-1:0]),
    .re    (accept),
    .raddr (sawq_pkg::SLOT_IDX_W'(req_data.slot_number - 4'd1)),
    .rdata (tag_rdata)
  );

  sawq_ram #(
    .WIDTH (sawq_pkg::TAG_BITS),
    .DEPTH (sawq_pkg::WAIT_DEPTH)
  ) u_wait_ram (
    .clk   (clk),
    .we    (wait_we),
    .waddr (tail),
    .wdata (alloc_tag[sawq_pkg::TAG_BITS-1:0]),
    .re    (accept),
    .raddr (head),
    .rdata (wait_rdata)
  );

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = sawq_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_found = 1'b1;
        free_idx   = sawq_pkg::SLOT_IDX_W'(i);
      end
    end
  end

  assign num_valid  = (cur_num != 4'd0) && (cur_num <= 4'(sawq_pkg::SLOTS));
  assign rel_idx    = sawq_pkg::SLOT_IDX_W'(cur_num - 4'd1);
  assign rel_busy   = busy[rel_idx];
  assign rel_chain  = (cur_func == sawq_pkg::FUNC_RELEASE) && num_valid && rel_busy &&
                      (fill != '0);
  assign queue_room = (fill < sawq_pkg::FILL_W'(sawq_pkg::WAIT_DEPTH));
  assign alloc_tag  = (state == sawq_pkg::SEQ_SECOND) ? 16'(wait_rdata) : cur_tag;

  always_comb begin
    alloc_res      = '0;
    alloc_res.tag_out = alloc_tag;
    alloc_res.last = 1'b1;
    if (free_found) begin
      alloc_res.status        = sawq_pkg::STATUS_ALLOCATED;
      alloc_res.slot_out      = 4'(free_idx) + 4'd1;
      alloc_res.waiting_count = 3'(fill);
    end else if (queue_room) begin
      alloc_res.status        = sawq_pkg::STATUS_QUEUED;
      alloc_res.waiting_count = 3'(fill + 1'b1);
    end else begin
      alloc_res.status        = sawq_pkg::STATUS_REJECTED;
      alloc_res.waiting_count = 3'(fill);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sawq_pkg::SEQ_IDLE: begin
        if (accept) begin
          state_next = sawq_pkg::SEQ_EXEC;
        end
      end
      sawq_pkg::SEQ_EXEC: begin
        if (out_free) begin
          state_next = rel_chain ? sawq_pkg::SEQ_SECOND : sawq_pkg::SEQ_IDLE;
        end
      end
      sawq_pkg::SEQ_SECOND: begin
        if (out_free) begin
          state_next = sawq_pkg::SEQ_IDLE;
        end
      end
      default: state_next = sawq_pkg::SEQ_IDLE;
    endcase
  end

  always_comb begin
    load_out = 1'b0;
    out_next = '0;
    tag_we   = 1'b0;
    wait_we  = 1'b0;
    busy_set = 1'b0;
    busy_clr = 1'b0;
    push     = 1'b0;
    pop      = 1'b0;
    case (state)
      sawq_pkg::SEQ_EXEC: begin
        if (out_free) begin
          load_out = 1'b1;
          if (cur_func == sawq_pkg::FUNC_ALLOC) begin
            out_next = alloc_res;
            tag_we   = free_found;
            busy_set = free_found;
            wait_we  = !free_found && queue_room;
            push     = !free_found && queue_room;
          end else if (!num_valid) begin
            out_next.status        = sawq_pkg::STATUS_INVALID;
            out_next.waiting_count = 3'(fill);
            out_next.last          = 1'b1;
          end else if (!rel_busy) begin
            out_next.status        = sawq_pkg::STATUS_ALREADY_FREE;
            out_next.slot_out      = cur_num;
            out_next.waiting_count = 3'(fill);
            out_next.last          = 1'b1;
          end else begin
            out_next.status        = sawq_pkg::STATUS_RELEASED;
            out_next.slot_out      = cur_num;
            out_next.tag_out       = 16'(tag_rdata);
            out_next.waiting_count = 3'(fill);
            out_next.last          = (fill == '0);
            busy_clr               = 1'b1;
            pop                    = (fill != '0);
          end
        end
      end
      sawq_pkg::SEQ_SECOND: begin
        if (out_free) begin
          load_out = 1'b1;
          out_next = alloc_res;
          tag_we   = 1'b1;
          busy_set = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sawq_pkg::SEQ_IDLE;
      busy      <= '0;
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= load_out || (res_valid && res_stall);
      if (busy_set) begin
        busy[free_idx] <= 1'b1;
      end
      if (busy_clr) begin
        busy[rel_idx] <= 1'b0;
      end
      if (push) begin
        tail <= (tail == sawq_pkg::WAIT_IDX_W'(sawq_pkg::WAIT_DEPTH - 1)) ? '0 : tail + 1'b1;
        fill <= fill + 1'b1;
      end
      if (pop) begin
        head <= (head == sawq_pkg::WAIT_IDX_W'(sawq_pkg::WAIT_DEPTH - 1)) ? '0 : head + 1'b1;
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_func <= req_data.func;
      cur_tag  <= 16'(req_data.requester_tag[sawq_pkg::TAG_BITS-1:0]);
      cur_num  <= req_data.slot_number;
    end
    if (load_out) begin
      res_data <= out_next;
    end
  end

endmodule

// ===== design/sawq_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module sawq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/sawq_checker.sv =====
// Port-level checker for the slot allocator, bound to the top level.
// Depends on sawq_pkg and slot_allocator_with_wait_queue_macros.svh.
`include "slot_allocator_with_wait_queue_macros.svh"

module sawq_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input sawq_pkg::req_t req_data,
  input logic           res_valid,
  input logic           res_stall,
  input sawq_pkg::res_t res_data
);

  `SAWQ_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_data), "result changed while stalled")
  `SAWQ_ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall, "request taken while another is in work")
  `SAWQ_ASSERT_NEXT(a_second_follows, res_valid && !res_stall && !res_data.last, res_valid, "allocation of a waiter did not follow its release")
  `SAWQ_ASSERT_SAME(a_first_is_release, res_valid && !res_data.last, res_data.status == sawq_pkg::STATUS_RELEASED && res_data.waiting_count != 3'd0, "non-final result is not a release with waiters")
  `SAWQ_ASSERT_SAME(a_queued_shape, res_valid && res_data.status == sawq_pkg::STATUS_QUEUED, res_data.slot_out == 4'd0 && res_data.waiting_count != 3'd0, "queued result with a slot or an empty queue")

endmodule

bind slot_allocator_with_wait_queue sawq_checker u_sawq_checker (.*);
